FILE: rtl/page_cache_recency_replacement_defines.svh
// Assertion macros used by the page cache back end.
`ifndef PAGE_CACHE_RECENCY_REPLACEMENT_DEFINES_SVH
`define PAGE_CACHE_RECENCY_REPLACEMENT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent, outside reset.
`define PCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/pcr_pkg.sv
// Package with the types and codes of the page cache replacement controller.
`default_nettype none
package pcr_pkg;
  localparam logic [1:0] MODE_GET    = 2'd0;
  localparam logic [1:0] MODE_CREATE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] page_id;
    logic [31:0] new_page_id;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot_index;
    logic [31:0] result_page_id;
    logic        writeback_valid;
    logic [31:0] writeback_page_id;
    logic        fetch_valid;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FLUSH,
    ST_CLOSE
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/page_cache_recency_replacement.sv
// Top level of the page cache tag and replacement controller.
// A get or create gives its single word after the slot scan and the commit step, once
// it leaves the two-entry queue; a flush walks every slot and then closes with a final word.
// The back end takes a new command only once the slot walk of the last one has ended.
// Words leave on a one-cycle strobe and cannot be stalled; busy rises when the queue is full.
// Synchronous active-low reset clears all stamps, dirty marks and sets the counter to one.
`default_nettype none
module page_cache_recency_replacement #(
  parameter int          CACHE_ENTRIES = 16,
  parameter logic [31:0] STAMP_MAX     = 32'd65535
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  pcr_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output pcr_pkg::out_word_t out_word,
  input  wire                cfg_we,
  input  wire  [31:0]        cfg_wdata
);
  logic [31:0]       null_page_id_r;
  logic              q_valid, q_pop;
  pcr_pkg::in_word_t q_word;

  always_ff @(posedge clk) begin
    if (!rst_n) null_page_id_r <= '0;
    else if (cfg_we) null_page_id_r <= cfg_wdata;
  end

  pcr_front #(.QUEUE_DEPTH(2)) u_front (
    .clk, .rst_n, .start, .busy, .in_word, .q_valid, .q_word, .q_pop
  );

  pcr_back #(.CACHE_ENTRIES(CACHE_ENTRIES), .STAMP_MAX(STAMP_MAX)) u_back (
    .clk, .rst_n, .null_page_id(null_page_id_r), .q_valid, .q_word, .q_pop,
    .out_valid(out_strobe), .out_word
  );
endmodule
`default_nettype wire

FILE: rtl/pcr_front.sv
// Front end: accepts commands, drops the unused mode and queues the rest.
`default_nettype none
module pcr_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  pcr_pkg::in_word_t   in_word,
  output logic                q_valid,
  output pcr_pkg::in_word_t   q_word,
  input  wire                 q_pop
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  pcr_pkg::in_word_t mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push;

  assign busy    = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign push    = start && !busy && (in_word.mode != pcr_pkg::MODE_UNUSED);
  assign q_valid = (cnt_r != '0);
  assign q_word  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop && q_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= (wp_r == AW'(QUEUE_DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= (rp_r == AW'(QUEUE_DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_word;
  end
endmodule
`default_nettype wire

FILE: rtl/pcr_back.sv
// Back end: walks the slots for lookup, victim choice and flush, then updates them.
`default_nettype none
`include "page_cache_recency_replacement_defines.svh"
module pcr_back #(
  parameter int          CACHE_ENTRIES = 16,
  parameter logic [31:0] STAMP_MAX     = 32'd65535
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire  [31:0]        null_page_id,
  input  wire                q_valid,
  input  pcr_pkg::in_word_t  q_word,
  output logic               q_pop,
  output logic               out_valid,
  output pcr_pkg::out_word_t out_word
);
  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [31:0]  page_r  [CACHE_ENTRIES];
  logic [31:0]  stamp_r [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] dirty_r;
  logic [31:0]  ctr_r, last_page_r;

  pcr_pkg::state_t   st_r, st_nxt;
  pcr_pkg::in_word_t cmd_r;
  logic [IW-1:0] idx_r;
  logic          found_r;
  logic [IW-1:0] hit_idx_r, vic_r, tgt;
  logic [31:0]   vic_stamp_r;
  logic [31:0]   cur_stamp;
  logic          match_now, last_idx;
  logic          out_valid_r;
  pcr_pkg::out_word_t out_r;

  // Stamp computation for the commit step.
  logic [31:0] key, ctr_a, ctr_b;
  logic        wrap;

  assign cur_stamp = stamp_r[idx_r];
  assign match_now = (cur_stamp != '0) && (page_r[idx_r] == cmd_r.page_id)
                     && (cmd_r.mode == pcr_pkg::MODE_GET);
  assign last_idx  = (idx_r == IW'(CACHE_ENTRIES-1));
  assign q_pop     = (st_r == pcr_pkg::ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign tgt       = found_r ? hit_idx_r : vic_r;

  assign key   = (cmd_r.mode == pcr_pkg::MODE_GET) ? cmd_r.page_id : null_page_id;
  assign wrap  = (ctr_r == STAMP_MAX);
  assign ctr_a = wrap ? 32'd1 : ctr_r;
  assign ctr_b = (last_page_r != key) ? ctr_a + 32'd1 : ctr_a;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pcr_pkg::ST_IDLE:
        if (q_valid) st_nxt = (q_word.mode == pcr_pkg::MODE_FLUSH)
                              ? pcr_pkg::ST_FLUSH : pcr_pkg::ST_SCAN;
      pcr_pkg::ST_SCAN:   if (match_now || last_idx) st_nxt = pcr_pkg::ST_COMMIT;
      pcr_pkg::ST_COMMIT: st_nxt = pcr_pkg::ST_IDLE;
      pcr_pkg::ST_FLUSH:  if (last_idx) st_nxt = pcr_pkg::ST_CLOSE;
      pcr_pkg::ST_CLOSE:  st_nxt = pcr_pkg::ST_IDLE;
      default:            st_nxt = pcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= pcr_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) stamp_r[i] <= '0;
      dirty_r     <= '0;
      ctr_r       <= 32'd1;
      last_page_r <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (st_r)
        pcr_pkg::ST_IDLE: begin
          idx_r       <= '0;
          found_r     <= 1'b0;
          vic_r       <= '0;
          vic_stamp_r <= '1;
          cmd_r       <= q_word;
        end
        pcr_pkg::ST_SCAN: begin
          // Strict compare keeps the lowest index among equal stamps.
          if (idx_r == '0 || cur_stamp < vic_stamp_r) begin
            vic_r       <= idx_r;
            vic_stamp_r <= cur_stamp;
          end
          if (match_now) begin
            found_r   <= 1'b1;
            hit_idx_r <= idx_r;
          end
          if (!last_idx) idx_r <= idx_r + 1'b1;
        end
        pcr_pkg::ST_COMMIT: begin
          // The stamp wrap clears every other stamp while the target takes the new one.
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (IW'(i) == tgt) stamp_r[i] <= ctr_b;
            else if (wrap)     stamp_r[i] <= '0;
          end
          ctr_r       <= ctr_b;
          last_page_r <= key;
          out_valid_r <= 1'b1;
          out_r.last  <= 1'b1;
          if (found_r) begin
            dirty_r[hit_idx_r] <= 1'b1;
            out_r.hit               <= 1'b1;
            out_r.slot_index        <= 4'(hit_idx_r);
            out_r.result_page_id    <= cmd_r.page_id;
            out_r.writeback_valid   <= 1'b0;
            out_r.writeback_page_id <= '0;
            out_r.fetch_valid       <= 1'b0;
          end else begin
            page_r[vic_r]  <= (cmd_r.mode == pcr_pkg::MODE_GET)
                              ? cmd_r.page_id : cmd_r.new_page_id;
            dirty_r[vic_r] <= (cmd_r.mode != pcr_pkg::MODE_GET);
            out_r.hit               <= 1'b0;
            out_r.slot_index        <= 4'(vic_r);
            out_r.result_page_id    <= (cmd_r.mode == pcr_pkg::MODE_GET)
                                       ? cmd_r.page_id : cmd_r.new_page_id;
            out_r.writeback_valid   <= dirty_r[vic_r];
            out_r.writeback_page_id <= dirty_r[vic_r] ? page_r[vic_r] : '0;
            out_r.fetch_valid       <= (cmd_r.mode == pcr_pkg::MODE_GET);
          end
        end
        pcr_pkg::ST_FLUSH: begin
          if (dirty_r[idx_r]) begin
            stamp_r[idx_r]          <= '0;
            dirty_r[idx_r]          <= 1'b0;
            out_valid_r             <= 1'b1;
            out_r.hit               <= 1'b0;
            out_r.slot_index        <= 4'(idx_r);
            out_r.result_page_id    <= '0;
            out_r.writeback_valid   <= 1'b1;
            out_r.writeback_page_id <= page_r[idx_r];
            out_r.fetch_valid       <= 1'b0;
            out_r.last              <= 1'b0;
          end
          if (!last_idx) idx_r <= idx_r + 1'b1;
        end
        pcr_pkg::ST_CLOSE: begin
          out_valid_r <= 1'b1;
          out_r       <= '{hit: 1'b0, slot_index: '0, result_page_id: '0,
                           writeback_valid: 1'b0, writeback_page_id: '0,
                           fetch_valid: 1'b0, last: 1'b1};
        end
        default: ;
      endcase
    end
  end

  `PCR_ASSERT_IMPL(a_hit_no_fetch, out_valid && out_word.hit,
                   !out_word.fetch_valid && !out_word.writeback_valid,
                   "hit result carries a fetch or writeback")
  `PCR_ASSERT_NEXT(a_commit_result, st_r == pcr_pkg::ST_COMMIT,
                   out_valid && out_word.last, "commit did not emit a final word")
  `PCR_ASSERT_IMPL(a_pop_idle, q_pop, st_r == pcr_pkg::ST_IDLE,
                   "queue popped while the back end was busy")
  `PCR_ASSERT_NEXT(a_ctr_valid, 1'b1, ctr_r != '0, "stamp counter reached zero")
endmodule
`default_nettype wire

FILE: bench/pcr_checker.sv
// Checker that predicts the page cache controller's result words and compares them.
`default_nettype none
module pcr_checker #(
  parameter int          CACHE_ENTRIES = 16,
  parameter logic [31:0] STAMP_MAX     = 32'd65535
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                busy,
  input  pcr_pkg::in_word_t  in_word,
  input  wire                out_strobe,
  input  pcr_pkg::out_word_t out_word,
  input  wire                cfg_we,
  input  wire  [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] null_id;
  logic [31:0] page_tab [CACHE_ENTRIES];
  logic [31:0] stamp_tab [CACHE_ENTRIES];
  logic        dirty_tab [CACHE_ENTRIES];
  logic [31:0] stamp_ctr;
  logic [31:0] recent_key;
  pcr_pkg::out_word_t due_words [$];

  assign pending = due_words.size();

  function automatic pcr_pkg::out_word_t mk_word(logic h, int s, logic [31:0] rp, logic wv,
                                                 logic [31:0] wp, logic fv, logic lst);
    pcr_pkg::out_word_t w;
    w.hit = h;
    w.slot_index = s[3:0];
    w.result_page_id = rp;
    w.writeback_valid = wv;
    w.writeback_page_id = wp;
    w.fetch_valid = fv;
    w.last = lst;
    return w;
  endfunction

  // Clears every stamp when the counter saturates, then advances on a new key.
  task automatic next_stamp(input logic [31:0] key, output logic [31:0] st);
    if (stamp_ctr == STAMP_MAX) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) stamp_tab[i] = '0;
      stamp_ctr = 32'd1;
    end
    if (recent_key != key) begin
      stamp_ctr = stamp_ctr + 32'd1;
      recent_key = key;
    end
    st = stamp_ctr;
  endtask

  function automatic int oldest_slot();
    int v;
    v = 0;
    for (int i = 1; i < CACHE_ENTRIES; i++)
      if (stamp_tab[i] < stamp_tab[v]) v = i;
    return v;
  endfunction

  task automatic predict_command(input pcr_pkg::in_word_t c);
    int          v;
    logic [31:0] st;
    logic        wb;
    bit          found;
    found = 0;
    case (c.mode)
      pcr_pkg::MODE_GET: begin
        for (int i = 0; i < CACHE_ENTRIES && !found; i++) begin
          if (stamp_tab[i] != 0 && page_tab[i] == c.page_id) begin
            found = 1;
            dirty_tab[i] = 1'b1;
            next_stamp(c.page_id, st);
            stamp_tab[i] = st;
            due_words.push_back(mk_word(1'b1, i, c.page_id, 1'b0, '0, 1'b0, 1'b1));
          end
        end
        if (!found) begin
          v = oldest_slot();
          wb = dirty_tab[v];
          due_words.push_back(mk_word(1'b0, v, c.page_id, wb, wb ? page_tab[v] : '0,
                                      1'b1, 1'b1));
          next_stamp(c.page_id, st);
          stamp_tab[v] = st;
          page_tab[v] = c.page_id;
          dirty_tab[v] = 1'b0;
        end
      end
      pcr_pkg::MODE_CREATE: begin
        v = oldest_slot();
        wb = dirty_tab[v];
        due_words.push_back(mk_word(1'b0, v, c.new_page_id, wb, wb ? page_tab[v] : '0,
                                    1'b0, 1'b1));
        next_stamp(null_id, st);
        stamp_tab[v] = st;
        dirty_tab[v] = 1'b1;
        page_tab[v] = c.new_page_id;
      end
      pcr_pkg::MODE_FLUSH: begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (dirty_tab[i]) begin
            due_words.push_back(mk_word(1'b0, i, '0, 1'b1, page_tab[i], 1'b0, 1'b0));
            stamp_tab[i] = '0;
            dirty_tab[i] = 1'b0;
          end
        end
        due_words.push_back(mk_word(1'b0, 0, '0, 1'b0, '0, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pcr_pkg::out_word_t e;
    if (!rst_n) begin
      null_id <= '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        page_tab[i] = '0;
        stamp_tab[i] = '0;
        dirty_tab[i] = 1'b0;
      end
      stamp_ctr = 32'd1;
      recent_key = '0;
      due_words.delete();
      fail_count <= 0;
      words_seen <= 0;
    end else begin
      if (out_strobe) begin
        words_seen <= words_seen + 1;
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word);
          fail_count <= fail_count + 1;
        end else begin
          e = due_words.pop_front();
          if (e.hit !== out_word.hit || e.slot_index !== out_word.slot_index ||
              e.result_page_id !== out_word.result_page_id ||
              e.writeback_valid !== out_word.writeback_valid ||
              e.writeback_page_id !== out_word.writeback_page_id ||
              e.fetch_valid !== out_word.fetch_valid || e.last !== out_word.last) begin
            $display({"%0t: mismatch expected hit=%b slot=%0d page=%h wb=%b wbpage=%h",
                      " fetch=%b last=%b"},
                     $time, e.hit, e.slot_index, e.result_page_id, e.writeback_valid,
                     e.writeback_page_id, e.fetch_valid, e.last);
            $display({"%0t:          actual   hit=%b slot=%0d page=%h wb=%b wbpage=%h",
                      " fetch=%b last=%b"},
                     $time, out_word.hit, out_word.slot_index, out_word.result_page_id,
                     out_word.writeback_valid, out_word.writeback_page_id,
                     out_word.fetch_valid, out_word.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_command(in_word);
      if (cfg_we) null_id <= cfg_wdata;
    end
  end
endmodule
`default_nettype wire

FILE: bench/tb_page_cache_recency_replacement.sv
// Testbench top: drives commands and register writes and reports the verdict.
`default_nettype none
module tb_page_cache_recency_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  pcr_pkg::in_word_t  in_word = '0;
  logic      out_strobe;
  pcr_pkg::out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int        fail_count, pending, words_seen;
  int        idle_cycles = 0;
  int        sent = 0;
  int        n_flush = 0;
  logic [31:0] pool [8];

  always #6 clk = ~clk;

  page_cache_recency_replacement u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  pcr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .words_seen(words_seen)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_page_cache_recency_replacement: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 150);
  endfunction

  // Holds the word until it is taken, then leaves start high if no gap follows.
  task automatic send(input logic [1:0] m, input logic [31:0] pid, input logic [31:0] npid);
    int g;
    start <= 1'b1;
    in_word <= '{mode: m, page_id: pid, new_page_id: npid};
    do @(posedge clk); while (busy);
    sent++;
    if (m == pcr_pkg::MODE_FLUSH) n_flush++;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_null(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int r;
    logic [31:0] pid;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      pid = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] : $urandom;
      if (r < 70) send(pcr_pkg::MODE_GET, pid, $urandom);
      else if (r < 92) send(pcr_pkg::MODE_CREATE, $urandom, pid);
      else if (r < 97) send(pcr_pkg::MODE_FLUSH, $urandom, $urandom);
      else send(pcr_pkg::MODE_UNUSED, pid, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    pool[0] = 32'h0;
    pool[1] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, hits, misses, creates, flushes and the unused mode.
    write_null(32'h0);
    send(pcr_pkg::MODE_GET, 32'h0, 32'h0);
    send(pcr_pkg::MODE_GET, 32'h0, 32'hFFFF_FFFF);
    send(pcr_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0);
    send(pcr_pkg::MODE_FLUSH, 32'h0, 32'h0);
    send(pcr_pkg::MODE_CREATE, 32'h0, 32'hFFFF_FFFF);
    send(pcr_pkg::MODE_CREATE, 32'hFFFF_FFFF, 32'h0);
    send(pcr_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0);
    send(pcr_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) send(pcr_pkg::MODE_GET, 32'h100 + i, 32'h0);
    send(pcr_pkg::MODE_GET, 32'hAAAA_5555, 32'h0);
    send(pcr_pkg::MODE_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(pcr_pkg::MODE_FLUSH, 32'h0, 32'h0);
    quiesce();

    write_null(32'hFFFF_FFFF);
    random_phase(80);
    quiesce();
    write_null($urandom);
    random_phase(90);
    quiesce();
    write_null(32'h0);
    random_phase(70);
    quiesce();

    $display("Run covered %0d commands, %0d of them flushes, and %0d result words checked.",
             sent, n_flush, words_seen);
    if (fail_count == 0) $display("tb_page_cache_recency_replacement: done, clean");
    else $display("tb_page_cache_recency_replacement: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

FILE: page_cache_recency_replacement.f
+incdir+rtl
rtl/pcr_pkg.sv
rtl/pcr_front.sv
rtl/pcr_back.sv
rtl/page_cache_recency_replacement.sv
bench/pcr_checker.sv
bench/tb_page_cache_recency_replacement.sv
